// File: rtl/vlc_pkg.sv
// ----------------------------------------------------------------------------
// Vehicle lamp controller package
// Shared types, event codes, lamp masks and a helper function.
// ----------------------------------------------------------------------------
package vlc_pkg;

    // Event codes carried by one request
    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_IGNITION = 3'd1,
        CMD_LIGHT    = 3'd2,
        CMD_RIGHT    = 3'd3,
        CMD_LEFT     = 3'd4
    } cmd_t;

    // Lamp operating mode
    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_LEFT  = 2'd2,
        MODE_PARK  = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FLASH_TICKS = 2'd0,
        CFG_LOW_DUTY    = 2'd1,
        CFG_HIGH_DUTY   = 2'd2
    } cfg_idx_t;

    // Lamp bit masks: right lamp, left lamp, buzzer
    localparam logic [2:0] LAMP_RIGHT = 3'b001;
    localparam logic [2:0] LAMP_LEFT  = 3'b010;
    localparam logic [2:0] LAMP_BUZZ  = 3'b100;
    localparam logic [2:0] LAMP_ALL   = 3'b111;

    localparam logic [6:0] DUTY_MAX   = 7'd100;
    localparam logic [6:0] FUEL_SCALE = 7'd100;

    localparam logic [7:0] FLASH_TICKS_RST = 8'd4;
    localparam logic [6:0] LOW_DUTY_RST    = 7'd10;
    localparam logic [6:0] HIGH_DUTY_RST   = 7'd90;

    typedef struct packed {
        logic [7:0] flash_ticks;
        logic [6:0] low_duty;
        logic [6:0] high_duty;
    } cfg_t;

    typedef struct packed {
        logic       ign_off;
        mode_t      mode;
        logic [2:0] light_presses;
        logic [1:0] right_presses;
        logic [1:0] left_presses;
        logic [7:0] tick_count;
        logic [2:0] lamp_bits;
        logic [6:0] duty_now;
        logic       report_pending;
    } state_t;

    typedef struct packed {
        logic       right_lamp;
        logic       left_lamp;
        logic       buzzer_on;
        logic       ignition_on;
        logic [6:0] headlight_duty;
        logic [1:0] light_mode;
        logic       report_valid;
        logic [6:0] fuel_percent;
    } result_t;

    localparam state_t STATE_RST = '{
        ign_off:        1'b1,
        mode:           MODE_OFF,
        light_presses:  3'd0,
        right_presses:  2'd0,
        left_presses:   2'd0,
        tick_count:     8'd0,
        lamp_bits:      3'd0,
        duty_now:       7'd0,
        report_pending: 1'b0
    };

    // Clamp a duty setting to 100 percent
    function automatic logic [6:0] sat_duty(input logic [6:0] d);
        return (d > DUTY_MAX) ? DUTY_MAX : d;
    endfunction

endpackage

// File: rtl/vlc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Vehicle lamp controller configuration registers
// Holds flash period and headlight duty settings written over the cfg port.
// ----------------------------------------------------------------------------
module vlc_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    output vlc_pkg::cfg_t    cfg
);

    vlc_pkg::cfg_t cfg_reg;
    vlc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg           = cfg_reg;

    // Decode the write; indexes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                vlc_pkg::CFG_FLASH_TICKS: cfg_next.flash_ticks = cfg_data;
                vlc_pkg::CFG_LOW_DUTY:    cfg_next.low_duty    = cfg_data[6:0];
                vlc_pkg::CFG_HIGH_DUTY:   cfg_next.high_duty   = cfg_data[6:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flash_ticks <= vlc_pkg::FLASH_TICKS_RST;
            cfg_reg.low_duty    <= vlc_pkg::LOW_DUTY_RST;
            cfg_reg.high_duty   <= vlc_pkg::HIGH_DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/vlc_rules.sv
// ----------------------------------------------------------------------------
// Vehicle lamp controller rule pass
// Applies one event to the state, then runs one pass of the lamp rules.
// ----------------------------------------------------------------------------
module vlc_rules (
    input  vlc_pkg::state_t  state_cur,
    input  vlc_pkg::cfg_t    cfg,
    input  logic [2:0]       command,
    input  logic [11:0]      fuel_sample,
    output vlc_pkg::state_t  state_nxt,
    output vlc_pkg::result_t result
);

    always_comb
    begin
        vlc_pkg::state_t st;
        logic            on;
        logic            rep;
        logic [18:0]     prod;
        logic [6:0]      fuel;

        st   = state_cur;
        on   = !state_cur.ign_off;
        rep  = 1'b0;
        fuel = 7'd0;
        prod = 19'(fuel_sample) * 19'(vlc_pkg::FUEL_SCALE);

        // Apply the event
        case (command)
            vlc_pkg::CMD_TICK:
            begin
                if (st.mode inside {vlc_pkg::MODE_RIGHT, vlc_pkg::MODE_LEFT})
                    st.tick_count = st.tick_count + 8'd1;
                else if (st.mode == vlc_pkg::MODE_PARK)
                    st.tick_count = 8'd1;
                st.report_pending = 1'b1;
            end
            vlc_pkg::CMD_IGNITION:
            begin
                st.ign_off = ~st.ign_off;
            end
            vlc_pkg::CMD_LIGHT:
            begin
                if (on)
                begin
                    st.light_presses = st.light_presses + 3'd1;
                    if (st.light_presses == 3'd3 && st.mode == vlc_pkg::MODE_OFF)
                        st.lamp_bits = vlc_pkg::LAMP_ALL;
                end
            end
            vlc_pkg::CMD_RIGHT:
            begin
                if (on && (st.mode inside {vlc_pkg::MODE_OFF, vlc_pkg::MODE_RIGHT}))
                begin
                    st.lamp_bits     = st.lamp_bits | vlc_pkg::LAMP_RIGHT | vlc_pkg::LAMP_BUZZ;
                    st.right_presses = st.right_presses + 2'd1;
                end
            end
            vlc_pkg::CMD_LEFT:
            begin
                if (on && (st.mode inside {vlc_pkg::MODE_OFF, vlc_pkg::MODE_LEFT}))
                begin
                    st.lamp_bits    = st.lamp_bits | vlc_pkg::LAMP_LEFT | vlc_pkg::LAMP_BUZZ;
                    st.left_presses = st.left_presses + 2'd1;
                end
            end
            default:
            begin
                st = st;
            end
        endcase

        if (!st.ign_off)
        begin
            // Right indicator: flash on period match, cancel on second press
            if (st.right_presses == 2'd1)
            begin
                st.mode = vlc_pkg::MODE_RIGHT;
                if (st.tick_count == cfg.flash_ticks)
                begin
                    st.lamp_bits  = st.lamp_bits ^ (vlc_pkg::LAMP_RIGHT | vlc_pkg::LAMP_BUZZ);
                    st.tick_count = 8'd0;
                end
            end
            else if (st.right_presses == 2'd2)
            begin
                st.lamp_bits     = st.lamp_bits & ~(vlc_pkg::LAMP_RIGHT | vlc_pkg::LAMP_BUZZ);
                st.mode          = vlc_pkg::MODE_OFF;
                st.right_presses = 2'd0;
            end

            // Left indicator: same scheme
            if (st.left_presses == 2'd1)
            begin
                st.mode = vlc_pkg::MODE_LEFT;
                if (st.tick_count == cfg.flash_ticks)
                begin
                    st.lamp_bits  = st.lamp_bits ^ (vlc_pkg::LAMP_LEFT | vlc_pkg::LAMP_BUZZ);
                    st.tick_count = 8'd0;
                end
            end
            else if (st.left_presses == 2'd2)
            begin
                st.lamp_bits    = st.lamp_bits & ~(vlc_pkg::LAMP_LEFT | vlc_pkg::LAMP_BUZZ);
                st.mode         = vlc_pkg::MODE_OFF;
                st.left_presses = 2'd0;
            end

            // Headlight duty steps and parking lights
            case (st.light_presses)
                3'd1:
                begin
                    st.duty_now = vlc_pkg::sat_duty(cfg.low_duty);
                end
                3'd2:
                begin
                    st.duty_now = vlc_pkg::sat_duty(cfg.high_duty);
                end
                3'd3:
                begin
                    if (st.mode inside {vlc_pkg::MODE_OFF, vlc_pkg::MODE_PARK})
                    begin
                        if (st.tick_count != 8'd0)
                        begin
                            st.lamp_bits  = st.lamp_bits ^ vlc_pkg::LAMP_ALL;
                            st.tick_count = 8'd0;
                        end
                        st.mode = vlc_pkg::MODE_PARK;
                    end
                end
                3'd4:
                begin
                    if (st.mode == vlc_pkg::MODE_PARK)
                    begin
                        st.lamp_bits = 3'd0;
                        st.mode      = vlc_pkg::MODE_OFF;
                    end
                    st.duty_now      = 7'd0;
                    st.light_presses = 3'd0;
                end
                default:
                begin
                    st.duty_now = st.duty_now;
                end
            endcase

            // Release a pending fuel report
            if (st.report_pending)
            begin
                rep               = 1'b1;
                fuel              = prod[18:12];
                st.report_pending = 1'b0;
            end
        end
        else
        begin
            // Ignition off: force everything dark
            st.duty_now  = 7'd0;
            st.lamp_bits = 3'd0;
        end

        state_nxt             = st;
        result.right_lamp     = st.lamp_bits[0];
        result.left_lamp      = st.lamp_bits[1];
        result.buzzer_on      = st.lamp_bits[2];
        result.ignition_on    = !st.ign_off;
        result.headlight_duty = st.duty_now;
        result.light_mode     = st.mode;
        result.report_valid   = rep;
        result.fuel_percent   = fuel;
    end

endmodule

// File: rtl/vehicle_lamp_controller.sv
// ----------------------------------------------------------------------------
// Vehicle lamp controller
// Event-driven indicator, parking light, headlight duty and fuel report logic.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register; the result register
// loads from the rule pass once it is free, so out_stall can hold it back.
// Throughput: one request per cycle while out_stall is low; the state update is one rule pass.
// Reset: rst_n clears the pipeline and lamp state (ignition off, mode off)
// and loads flash_ticks 4, low_duty 10, high_duty 90.
module vehicle_lamp_controller (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [11:0] fuel_sample,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        right_lamp,
    output logic        left_lamp,
    output logic        buzzer_on,
    output logic        ignition_on,
    output logic [6:0]  headlight_duty,
    output logic [1:0]  light_mode,
    output logic        report_valid,
    output logic [6:0]  fuel_percent,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    vlc_pkg::cfg_t    cfg;
    vlc_pkg::state_t  state_reg;
    vlc_pkg::state_t  state_next;
    vlc_pkg::result_t result_reg;
    vlc_pkg::result_t result_next;

    logic        in_valid_reg;
    logic [2:0]  command_reg;
    logic [11:0] fuel_sample_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        in_take;

    vlc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vlc_rules u_rules (
        .state_cur   (state_reg),
        .cfg         (cfg),
        .command     (command_reg),
        .fuel_sample (fuel_sample_reg),
        .state_nxt   (state_next),
        .result      (result_next)
    );

    // Move the held request into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Hold request valid and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= vlc_pkg::STATE_RST;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;
        end
    end

    // Capture request payload and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            command_reg     <= command;
            fuel_sample_reg <= fuel_sample;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign right_lamp     = result_reg.right_lamp;
    assign left_lamp      = result_reg.left_lamp;
    assign buzzer_on      = result_reg.buzzer_on;
    assign ignition_on    = result_reg.ignition_on;
    assign headlight_duty = result_reg.headlight_duty;
    assign light_mode     = result_reg.light_mode;
    assign report_valid   = result_reg.report_valid;
    assign fuel_percent   = result_reg.fuel_percent;

endmodule

// File: rtl/vlc_checker.sv
// ----------------------------------------------------------------------------
// Vehicle lamp controller port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module vlc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  command,
    input logic [11:0] fuel_sample,
    input logic        out_valid,
    input logic        out_stall,
    input logic        right_lamp,
    input logic        left_lamp,
    input logic        buzzer_on,
    input logic        ignition_on,
    input logic [6:0]  headlight_duty,
    input logic [1:0]  light_mode,
    input logic        report_valid,
    input logic [6:0]  fuel_percent
);

    // Hold a stalled request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(command) && $stable(fuel_sample))
        else $error("stalled request changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fuel_percent)
            && $stable(light_mode) && $stable(headlight_duty))
        else $error("stalled result changed");

    // Ignition off means dark lamps, zero duty and no report
    a_ign_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ignition_on |-> !right_lamp && !left_lamp && !buzzer_on
            && headlight_duty == 7'd0 && !report_valid)
        else $error("output active with ignition off");

    // Fuel field is zero without a report, below 100 with one
    a_fuel_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (report_valid ? (fuel_percent < 7'd100) : (fuel_percent == 7'd0)))
        else $error("fuel percent out of range");

    // Duty never exceeds 100 percent
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> headlight_duty <= 7'd100)
        else $error("headlight duty above 100");

endmodule

bind vehicle_lamp_controller vlc_checker u_vlc_checker (.*);

// File: tb/vehicle_lamp_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vehicle lamp controller testbench
// Sends tick, ignition and button events under random idling and a long
// result hold-off, rewrites the timing and duty registers between phases,
// and checks every lamp result field by field against a local predictor.
// ----------------------------------------------------------------------------
module vehicle_lamp_controller_tb;

    // Command codes the block treats as no event
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int IDLE_PCT      = 11;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 5000;

    // ------------------------------------------------------------------------
    // Lamp state predictor and result store
    // ------------------------------------------------------------------------
    class lamp_scoreboard;
        logic [7:0] flash_ticks;
        logic [6:0] low_duty;
        logic [6:0] high_duty;

        logic            ign_off;
        vlc_pkg::mode_t  mode;
        logic [2:0]      light_presses;
        logic [1:0]      right_presses;
        logic [1:0]      left_presses;
        logic [7:0]      tick_count;
        logic [2:0]      lamp_bits;
        logic [6:0]      duty_now;
        logic            report_pending;

        vlc_pkg::result_t lamp_results_due[$];
        int errors;
        int requests;
        int results;
        int reports;
        int dark_results;

        function new();
            flash_ticks    = vlc_pkg::FLASH_TICKS_RST;
            low_duty       = vlc_pkg::LOW_DUTY_RST;
            high_duty      = vlc_pkg::HIGH_DUTY_RST;
            ign_off        = 1'b1;
            mode           = vlc_pkg::MODE_OFF;
            light_presses  = '0;
            right_presses  = '0;
            left_presses   = '0;
            tick_count     = '0;
            lamp_bits      = '0;
            duty_now       = '0;
            report_pending = 1'b0;
            errors         = 0;
            requests       = 0;
            results        = 0;
            reports        = 0;
            dark_results   = 0;
        endfunction

        function void set_register(vlc_pkg::cfg_idx_t idx, logic [7:0] data);
            case (idx)
                vlc_pkg::CFG_FLASH_TICKS: flash_ticks = data;
                vlc_pkg::CFG_LOW_DUTY:    low_duty    = data[6:0];
                vlc_pkg::CFG_HIGH_DUTY:   high_duty   = data[6:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return lamp_results_due.size();
        endfunction

        function logic [6:0] clamp_duty(logic [6:0] d);
            return (d > vlc_pkg::DUTY_MAX) ? vlc_pkg::DUTY_MAX : d;
        endfunction

        // Run one indicator: flash while armed, drop on the second press
        function void step_indicator(inout logic [1:0] presses,
                                     input vlc_pkg::mode_t which,
                                     input logic [2:0] lamp);
            if (presses == 2'd1) begin
                mode = which;
                if (tick_count == flash_ticks) begin
                    lamp_bits  = lamp_bits ^ (lamp | vlc_pkg::LAMP_BUZZ);
                    tick_count = '0;
                end
            end else if (presses == 2'd2) begin
                lamp_bits = lamp_bits & ~(lamp | vlc_pkg::LAMP_BUZZ);
                mode      = vlc_pkg::MODE_OFF;
                presses   = '0;
            end
        endfunction

        // Apply one event plus one rule pass, return the lamp outputs
        function vlc_pkg::result_t apply_event(logic [2:0] cmd, logic [11:0] fuel);
            vlc_pkg::result_t r;
            logic             ign_was_on;
            logic [18:0]      scaled;
            ign_was_on = !ign_off;
            r          = '0;

            case (cmd)
                vlc_pkg::CMD_TICK: begin
                    if (mode == vlc_pkg::MODE_RIGHT || mode == vlc_pkg::MODE_LEFT)
                        tick_count = tick_count + 8'd1;
                    else if (mode == vlc_pkg::MODE_PARK)
                        tick_count = 8'd1;
                    report_pending = 1'b1;
                end
                vlc_pkg::CMD_IGNITION: ign_off = !ign_off;
                vlc_pkg::CMD_LIGHT: begin
                    if (ign_was_on) begin
                        light_presses = light_presses + 3'd1;
                        if (light_presses == 3'd3 && mode == vlc_pkg::MODE_OFF)
                            lamp_bits = vlc_pkg::LAMP_ALL;
                    end
                end
                vlc_pkg::CMD_RIGHT: begin
                    if (ign_was_on && (mode == vlc_pkg::MODE_OFF
                                       || mode == vlc_pkg::MODE_RIGHT)) begin
                        lamp_bits     = lamp_bits | vlc_pkg::LAMP_RIGHT | vlc_pkg::LAMP_BUZZ;
                        right_presses = right_presses + 2'd1;
                    end
                end
                vlc_pkg::CMD_LEFT: begin
                    if (ign_was_on && (mode == vlc_pkg::MODE_OFF
                                       || mode == vlc_pkg::MODE_LEFT)) begin
                        lamp_bits    = lamp_bits | vlc_pkg::LAMP_LEFT | vlc_pkg::LAMP_BUZZ;
                        left_presses = left_presses + 2'd1;
                    end
                end
                default: ;
            endcase

            if (!ign_off) begin
                step_indicator(right_presses, vlc_pkg::MODE_RIGHT, vlc_pkg::LAMP_RIGHT);
                step_indicator(left_presses, vlc_pkg::MODE_LEFT, vlc_pkg::LAMP_LEFT);
                if (light_presses == 3'd1) begin
                    duty_now = clamp_duty(low_duty);
                end else if (light_presses == 3'd2) begin
                    duty_now = clamp_duty(high_duty);
                end else if (light_presses == 3'd3) begin
                    // parking lights toggle once per tick seen
                    if (mode == vlc_pkg::MODE_OFF || mode == vlc_pkg::MODE_PARK) begin
                        if (tick_count != 8'd0) begin
                            lamp_bits  = lamp_bits ^ vlc_pkg::LAMP_ALL;
                            tick_count = '0;
                        end
                        mode = vlc_pkg::MODE_PARK;
                    end
                end else if (light_presses == 3'd4) begin
                    if (mode == vlc_pkg::MODE_PARK) begin
                        lamp_bits = lamp_bits & ~vlc_pkg::LAMP_ALL;
                        mode      = vlc_pkg::MODE_OFF;
                    end
                    duty_now      = '0;
                    light_presses = '0;
                end
                if (report_pending) begin
                    scaled          = {7'd0, fuel} * 19'd100;
                    r.report_valid  = 1'b1;
                    r.fuel_percent  = scaled[18:12];
                    report_pending  = 1'b0;
                    reports++;
                end
            end else begin
                duty_now  = '0;
                lamp_bits = '0;
                dark_results++;
            end

            r.right_lamp     = lamp_bits[0];
            r.left_lamp      = lamp_bits[1];
            r.buzzer_on      = lamp_bits[2];
            r.ignition_on    = !ign_off;
            r.headlight_duty = duty_now;
            r.light_mode     = mode;
            return r;
        endfunction

        function void note_request(logic [2:0] cmd, logic [11:0] fuel);
            requests++;
            lamp_results_due.push_back(apply_event(cmd, fuel));
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("result %0d field %s got %0d want %0d",
                                          results, name, got, want));
        endtask

        task check_result(vlc_pkg::result_t got);
            vlc_pkg::result_t want;
            if (lamp_results_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = lamp_results_due.pop_front();
                check_field("right_lamp", got.right_lamp, want.right_lamp);
                check_field("left_lamp", got.left_lamp, want.left_lamp);
                check_field("buzzer_on", got.buzzer_on, want.buzzer_on);
                check_field("ignition_on", got.ignition_on, want.ignition_on);
                check_field("headlight_duty", got.headlight_duty, want.headlight_duty);
                check_field("light_mode", got.light_mode, want.light_mode);
                check_field("report_valid", got.report_valid, want.report_valid);
                check_field("fuel_percent", got.fuel_percent, want.fuel_percent);
                results++;
            end
        endtask

        task final_check();
            if (lamp_results_due.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          lamp_results_due.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [11:0] fuel_sample;
    logic        out_valid;
    logic        out_stall;
    logic        right_lamp;
    logic        left_lamp;
    logic        buzzer_on;
    logic        ignition_on;
    logic [6:0]  headlight_duty;
    logic [1:0]  light_mode;
    logic        report_valid;
    logic [6:0]  fuel_percent;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    logic calm;
    logic hold_off;
    logic ign_shadow_off = 1'b1;
    int   settings       = 1;

    lamp_scoreboard sb;

    vehicle_lamp_controller u_top (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Watch both channels at the clock edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        vlc_pkg::result_t got;
        if (rst_n && in_valid && !in_stall)
            sb.note_request(command, fuel_sample);
        if (rst_n && out_valid && !out_stall) begin
            got.right_lamp     = right_lamp;
            got.left_lamp      = left_lamp;
            got.buzzer_on      = buzzer_on;
            got.ignition_on    = ignition_on;
            got.headlight_duty = headlight_duty;
            got.light_mode     = light_mode;
            got.report_valid   = report_valid;
            got.fuel_percent   = fuel_percent;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int   hold_left;
        logic held_once;
        hold_left = 0;
        held_once = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off && !held_once) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!hold_off)
                held_once = 1'b0;
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side helpers
    // ------------------------------------------------------------------------
    function automatic logic [11:0] random_fuel();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 12'h000;
        if (r == 1)
            return 12'hFFF;
        return 12'($urandom_range(0, 4095));
    endfunction

    // Mostly ignition-on traffic; switch back on quickly when off
    function automatic logic [2:0] pick_command(int tick_pct);
        int r;
        if (ign_shadow_off && $urandom_range(0, 99) < 40)
            return vlc_pkg::CMD_IGNITION;
        r = $urandom_range(0, 99);
        if (r < tick_pct)
            return vlc_pkg::CMD_TICK;
        r = $urandom_range(0, 99);
        if (r < 4)
            return vlc_pkg::CMD_IGNITION;
        if (r < 7)
            return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        if (r < 37)
            return vlc_pkg::CMD_LIGHT;
        if (r < 68)
            return vlc_pkg::CMD_RIGHT;
        return vlc_pkg::CMD_LEFT;
    endfunction

    // Offer one request and hold it until accepted
    task automatic send(input logic [2:0] cmd, input logic [11:0] fuel);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        fuel_sample <= fuel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == vlc_pkg::CMD_IGNITION)
            ign_shadow_off = !ign_shadow_off;
    endtask

    task automatic run_random(input int count, input int tick_pct);
        repeat (count)
            send(pick_command(tick_pct), random_fuel());
    endtask

    task automatic run_ticks(input int count);
        repeat (count)
            send(vlc_pkg::CMD_TICK, random_fuel());
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input vlc_pkg::cfg_idx_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic set_registers(input logic [7:0] flash, input logic [7:0] low,
                                 input logic [7:0] high);
        wait_idle();
        write_reg(vlc_pkg::CFG_FLASH_TICKS, flash);
        write_reg(vlc_pkg::CFG_LOW_DUTY, low);
        write_reg(vlc_pkg::CFG_HIGH_DUTY, high);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Bring the lamps back to ignition on, mode off
    task automatic return_to_off();
        wait_idle();
        while (sb.ign_off || sb.mode != vlc_pkg::MODE_OFF) begin
            if (sb.ign_off)
                send(vlc_pkg::CMD_IGNITION, random_fuel());
            else if (sb.mode == vlc_pkg::MODE_RIGHT)
                send(vlc_pkg::CMD_RIGHT, random_fuel());
            else if (sb.mode == vlc_pkg::MODE_LEFT)
                send(vlc_pkg::CMD_LEFT, random_fuel());
            else
                send(vlc_pkg::CMD_LIGHT, random_fuel());
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        sb = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        command     <= vlc_pkg::CMD_TICK;
        fuel_sample <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= vlc_pkg::CFG_FLASH_TICKS;
        cfg_data    <= '0;
        calm        <= 1'b0;
        hold_off    <= 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // Ignition off: report held, presses and spare codes ignored
        send(vlc_pkg::CMD_TICK, 12'hFFF);
        send(vlc_pkg::CMD_LIGHT, 12'h000);
        send(vlc_pkg::CMD_RIGHT, 12'h000);
        send(CMD_SPARE_LO, 12'h555);
        // Ignition on releases the held report at full scale
        send(vlc_pkg::CMD_IGNITION, 12'hFFF);
        // Headlight: low, high, parking on third press
        send(vlc_pkg::CMD_LIGHT, 12'h000);
        send(vlc_pkg::CMD_LIGHT, 12'h000);
        send(vlc_pkg::CMD_LIGHT, 12'hAAA);
        send(vlc_pkg::CMD_TICK, 12'h000);
        send(vlc_pkg::CMD_TICK, 12'h800);
        send(vlc_pkg::CMD_RIGHT, 12'h001);
        send(vlc_pkg::CMD_LIGHT, 12'h7FF);
        // Right indicator through one flash, left press ignored
        send(vlc_pkg::CMD_RIGHT, 12'h123);
        run_ticks(4);
        send(vlc_pkg::CMD_LEFT, 12'h456);
        send(vlc_pkg::CMD_RIGHT, 12'h789);
        // Left indicator across an ignition cycle
        send(vlc_pkg::CMD_LEFT, 12'hFFE);
        send(vlc_pkg::CMD_TICK, 12'h001);
        send(vlc_pkg::CMD_IGNITION, 12'h000);
        send(vlc_pkg::CMD_TICK, 12'h3FF);
        send(vlc_pkg::CMD_LEFT, 12'h000);
        send(vlc_pkg::CMD_IGNITION, 12'hC00);
        send(vlc_pkg::CMD_LEFT, 12'h000);
        send(CMD_SPARE_HI, 12'hFFF);

        run_random(250, 45);

        set_registers(8'd1, 8'd0, 8'd100);
        run_random(200, 40);

        // Flash on zero count, both duties above the clamp; no idling here
        set_registers(8'd0, 8'hFF, 8'hE5);
        calm <= 1'b1;
        run_random(200, 50);
        calm <= 1'b0;

        // Longest flash period: let each indicator count all the way up
        set_registers(8'hFF, 8'd100, 8'd0);
        return_to_off();
        send(vlc_pkg::CMD_RIGHT, random_fuel());
        run_ticks(260);
        return_to_off();
        send(vlc_pkg::CMD_LEFT, random_fuel());
        run_ticks(260);
        run_random(80, 60);

        // Hold results back while requests keep coming
        set_registers(8'($urandom_range(1, 8)), 8'($urandom), 8'($urandom));
        calm     <= 1'b1;
        hold_off <= 1'b1;
        run_random(120, 45);
        hold_off <= 1'b0;
        calm     <= 1'b0;

        // Drain and finish
        in_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        sb.final_check();
        $display("Run covered %0d requests and %0d checked results over %0d register settings",
                 sb.requests, sb.results, settings);
        $display("%0d fuel reports, %0d results with ignition off, one %0d-cycle hold-off",
                 sb.reports, sb.dark_results, HOLD_CYCLES);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop if the block hangs
    initial begin : watchdog
        #(1_000_000);
        $display("Timeout waiting for the block");
        $display("FAIL");
        $finish;
    end

endmodule
